[rtl/segment_allocator_fit_policy_assert.svh]
// assertion macros for the segment allocator checker
`ifndef SEGMENT_ALLOCATOR_FIT_POLICY_ASSERT_SVH
`define SEGMENT_ALLOCATOR_FIT_POLICY_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SGA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SGA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sgalloc_pkg.sv]
package sgalloc_pkg;

    localparam int SZ_W = 16;
    localparam logic [SZ_W-1:0] POOL_RST = 16'd4096;

    typedef logic [2:0] t_st;
    localparam t_st ST_OK       = 3'd0;
    localparam t_st ST_NOFIT    = 3'd1;
    localparam t_st ST_NOTALLOC = 3'd2;
    localparam t_st ST_BADSIZE  = 3'd3;
    localparam t_st ST_FULL     = 3'd4;

    typedef logic [1:0] t_cmdc;
    localparam t_cmdc CMD_ALLOC   = 2'd0;
    localparam t_cmdc CMD_FREE    = 2'd1;
    localparam t_cmdc CMD_REALLOC = 2'd2;

    typedef logic [1:0] t_pol;
    localparam t_pol POL_BEST  = 2'd1;
    localparam t_pol POL_WORST = 2'd2;

    typedef logic [4:0] t_op;
    localparam t_op OP_NOP          = 5'd0;
    localparam t_op OP_LOAD         = 5'd1;
    localparam t_op OP_PTR0         = 5'd2;
    localparam t_op OP_FIT_STEP     = 5'd3;
    localparam t_op OP_FIND_STEP    = 5'd4;
    localparam t_op OP_FOUND        = 5'd5;
    localparam t_op OP_ALLOC_EXACT  = 5'd6;
    localparam t_op OP_ALLOC_SPLIT  = 5'd7;
    localparam t_op OP_FREE_MARK    = 5'd8;
    localparam t_op OP_MERGE_NEXT   = 5'd9;
    localparam t_op OP_PTR_PREV     = 5'd10;
    localparam t_op OP_MERGE_PREV   = 5'd11;
    localparam t_op OP_SHRINK_MERGE = 5'd12;
    localparam t_op OP_SHRINK_SPLIT = 5'd13;
    localparam t_op OP_EXTEND       = 5'd14;
    localparam t_op OP_EXTEND_EXACT = 5'd15;
    localparam t_op OP_HOLE_START   = 5'd16;
    localparam t_op OP_HOLE_STEP    = 5'd17;
    localparam t_op OP_OUT_LOAD     = 5'd18;

    typedef logic [1:0] t_rsel;
    localparam t_rsel RSEL_ZERO = 2'd0;
    localparam t_rsel RSEL_ADDR = 2'd1;
    localparam t_rsel RSEL_NA   = 2'd2;

    typedef struct packed {
        t_op   op;
        t_st   st;
        t_rsel rsel;
    } t_dp_cmd;

    typedef struct packed {
        t_cmdc cmdc;
        logic  size_zero;
        logic  size_gt_free;
        logic  ptr_end;
        logic  cand;
        logic  first_pol;
        logic  pick_valid;
        logic  pick_exact;
        logic  full;
        logic  base_eq;
        logic  rd_used;
        logic  f_nz;
        logic  shrink;
        logic  grow;
        logic  next_fits;
        logic  next_exact;
    } t_dp_stat;

endpackage

[rtl/sgalloc_dp.sv]
module sgalloc_dp #(
    parameter int MAX_SEGS  = 32,
    parameter int ADDR_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sgalloc_pkg::SZ_W-1:0] i_cfg_wdata,
    input  logic [1:0]                  i_cmd,
    input  logic [ADDR_BITS-1:0]        i_req_addr,
    input  logic [sgalloc_pkg::SZ_W-1:0] i_req_size,
    input  logic [1:0]                  i_fit_policy,
    input  sgalloc_pkg::t_dp_cmd        i_dp_cmd,
    output sgalloc_pkg::t_dp_stat       o_dp_stat,
    output logic [2:0]                  o_status,
    output logic [sgalloc_pkg::SZ_W-1:0] o_result_addr,
    output logic [sgalloc_pkg::SZ_W-1:0] o_free_total,
    output logic [$clog2(MAX_SEGS+1)-1:0] o_hole_total
);

    localparam int SW   = sgalloc_pkg::SZ_W;
    localparam int IW   = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam int CW   = $clog2(MAX_SEGS + 1);
    localparam int AEFF = (ADDR_BITS < SW) ? ADDR_BITS : SW;
    localparam int LAST = MAX_SEGS - 1;

    logic [SW-1:0]       r_base [MAX_SEGS];
    logic [SW-1:0]       r_len  [MAX_SEGS];
    logic [MAX_SEGS-1:0] r_used;
    logic [SW-1:0]       n_base [MAX_SEGS];
    logic [SW-1:0]       n_len  [MAX_SEGS];
    logic [MAX_SEGS-1:0] n_used;

    logic [CW-1:0] r_count;
    logic [SW-1:0] r_free;
    logic [CW-1:0] r_ptr;
    logic [1:0]    r_cmdc;
    logic [SW-1:0] r_addr;
    logic [SW-1:0] r_size;
    logic [1:0]    r_pol;
    logic          r_pv;
    logic [CW-1:0] r_pi;
    logic [SW-1:0] r_plen;
    logic [SW-1:0] r_pbase;
    logic [SW-1:0] r_na;
    logic [CW-1:0] r_f;
    logic [SW-1:0] r_flen;
    logic [CW-1:0] r_holes;
    logic [2:0]    r_st;
    logic [SW-1:0] r_ra;
    logic [2:0]    r_o_st;
    logic [SW-1:0] r_o_ra;
    logic [SW-1:0] r_o_free;
    logic [CW-1:0] r_o_holes;

    logic          rd_ok;
    logic [IW-1:0] rd_idx;
    logic [SW-1:0] rd_base;
    logic [SW-1:0] rd_len;
    logic          rd_used;
    logic          cand;
    logic          take;
    logic [SW-1:0] d_shr;
    logic [SW-1:0] d_gr;

    // single read port at the scan pointer
    assign rd_ok   = r_ptr < CW'(MAX_SEGS);
    assign rd_idx  = r_ptr[IW-1:0];
    assign rd_base = rd_ok ? r_base[rd_idx] : '0;
    assign rd_len  = rd_ok ? r_len[rd_idx] : '0;
    assign rd_used = rd_ok ? r_used[rd_idx] : 1'b1;

    assign d_shr = r_flen - r_size;
    assign d_gr  = r_size - r_flen;

    assign cand = (r_ptr < r_count) && !rd_used && (rd_len >= r_size);

    always_comb begin
        take = 1'b0;
        if (cand) begin
            if (r_pol == sgalloc_pkg::POL_BEST) begin
                take = !r_pv || (rd_len < r_plen);
            end else if (r_pol == sgalloc_pkg::POL_WORST) begin
                take = !r_pv || (rd_len > r_plen);
            end else begin
                take = !r_pv;
            end
        end
    end

    assign o_dp_stat.cmdc         = r_cmdc;
    assign o_dp_stat.size_zero    = r_size == '0;
    assign o_dp_stat.size_gt_free = r_size > r_free;
    assign o_dp_stat.ptr_end      = r_ptr >= r_count;
    assign o_dp_stat.cand         = cand;
    assign o_dp_stat.first_pol    = (r_pol != sgalloc_pkg::POL_BEST) &&
                                    (r_pol != sgalloc_pkg::POL_WORST);
    assign o_dp_stat.pick_valid   = r_pv;
    assign o_dp_stat.pick_exact   = r_plen == r_size;
    assign o_dp_stat.full         = r_count >= CW'(MAX_SEGS);
    assign o_dp_stat.base_eq      = rd_base == r_addr;
    assign o_dp_stat.rd_used      = rd_used;
    assign o_dp_stat.f_nz         = r_f != '0;
    assign o_dp_stat.shrink       = r_size < r_flen;
    assign o_dp_stat.grow         = r_size > r_flen;
    assign o_dp_stat.next_fits    = rd_len >= d_gr;
    assign o_dp_stat.next_exact   = rd_len == d_gr;

    // per-entry table update, each entry looks only at its neighbours
    always_comb begin
        logic [CW-1:0] v_j;
        n_base = r_base;
        n_len  = r_len;
        n_used = r_used;
        for (int j = 0; j < MAX_SEGS; j++) begin
            v_j = CW'(j);
            case (i_dp_cmd.op)
                sgalloc_pkg::OP_ALLOC_EXACT: begin
                    if (v_j == r_pi) n_used[j] = 1'b1;
                end
                sgalloc_pkg::OP_ALLOC_SPLIT: begin
                    if (v_j == r_pi) begin
                        n_len[j]  = r_size;
                        n_used[j] = 1'b1;
                    end else if (v_j == r_pi + CW'(1)) begin
                        n_base[j] = r_pbase + r_size;
                        n_len[j]  = r_plen - r_size;
                        n_used[j] = 1'b0;
                    end else if (v_j > r_pi + CW'(1)) begin
                        if (j > 0) begin
                            n_base[j] = r_base[j-1];
                            n_len[j]  = r_len[j-1];
                            n_used[j] = r_used[j-1];
                        end
                    end
                end
                sgalloc_pkg::OP_FREE_MARK: begin
                    if (v_j == r_f) n_used[j] = 1'b0;
                end
                sgalloc_pkg::OP_MERGE_NEXT, sgalloc_pkg::OP_EXTEND_EXACT: begin
                    if (v_j == r_f) begin
                        if (i_dp_cmd.op == sgalloc_pkg::OP_EXTEND_EXACT) begin
                            n_len[j] = r_size;
                        end else if (j < LAST) begin
                            n_len[j] = r_len[j] + r_len[j+1];
                        end
                    end else if (v_j > r_f) begin
                        if (j < LAST) begin
                            n_base[j] = r_base[j+1];
                            n_len[j]  = r_len[j+1];
                            n_used[j] = r_used[j+1];
                        end
                    end
                end
                sgalloc_pkg::OP_MERGE_PREV: begin
                    if (v_j == r_f - CW'(1)) begin
                        if (j < LAST) n_len[j] = r_len[j] + r_len[j+1];
                    end else if (v_j >= r_f) begin
                        if (j < LAST) begin
                            n_base[j] = r_base[j+1];
                            n_len[j]  = r_len[j+1];
                            n_used[j] = r_used[j+1];
                        end
                    end
                end
                sgalloc_pkg::OP_SHRINK_MERGE: begin
                    if (v_j == r_f) begin
                        n_len[j] = r_size;
                    end else if (v_j == r_f + CW'(1)) begin
                        n_base[j] = r_addr + r_size;
                        n_len[j]  = r_len[j] + d_shr;
                    end
                end
                sgalloc_pkg::OP_SHRINK_SPLIT: begin
                    if (v_j == r_f) begin
                        n_len[j] = r_size;
                    end else if (v_j == r_f + CW'(1)) begin
                        n_base[j] = r_addr + r_size;
                        n_len[j]  = d_shr;
                        n_used[j] = 1'b0;
                    end else if (v_j > r_f + CW'(1)) begin
                        if (j > 0) begin
                            n_base[j] = r_base[j-1];
                            n_len[j]  = r_len[j-1];
                            n_used[j] = r_used[j-1];
                        end
                    end
                end
                sgalloc_pkg::OP_EXTEND: begin
                    if (v_j == r_f) begin
                        n_len[j] = r_size;
                    end else if (v_j == r_f + CW'(1)) begin
                        n_base[j] = r_base[j] + d_gr;
                        n_len[j]  = r_len[j] - d_gr;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // table storage, entry zero carries the reset segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base[0] <= '0;
            r_len[0]  <= sgalloc_pkg::POOL_RST;
        end else if (i_cfg_we) begin
            r_base[0] <= '0;
            r_len[0]  <= i_cfg_wdata;
        end else begin
            r_base <= n_base;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= CW'(1);
            r_free  <= sgalloc_pkg::POOL_RST;
            r_ptr   <= '0;
            r_pv    <= 1'b0;
        end else if (i_cfg_we) begin
            r_used  <= '0;
            r_count <= CW'(1);
            r_free  <= i_cfg_wdata;
        end else begin
            r_used <= n_used;
            case (i_dp_cmd.op)
                sgalloc_pkg::OP_LOAD: begin
                    r_ptr  <= '0;
                    r_cmdc <= i_cmd;
                    r_addr <= SW'(i_req_addr[AEFF-1:0]);
                    r_size <= i_req_size;
                    r_pol  <= i_fit_policy;
                end
                sgalloc_pkg::OP_PTR0: begin
                    r_ptr <= '0;
                    r_pv  <= 1'b0;
                end
                sgalloc_pkg::OP_FIT_STEP: begin
                    if (take) begin
                        r_pv    <= 1'b1;
                        r_pi    <= r_ptr;
                        r_plen  <= rd_len;
                        r_pbase <= rd_base;
                    end
                    r_ptr <= r_ptr + CW'(1);
                end
                sgalloc_pkg::OP_FIND_STEP: begin
                    r_ptr <= r_ptr + CW'(1);
                end
                sgalloc_pkg::OP_FOUND: begin
                    r_f    <= r_ptr;
                    r_flen <= rd_len;
                    r_ptr  <= r_ptr + CW'(1);
                end
                sgalloc_pkg::OP_ALLOC_EXACT: begin
                    r_free <= r_free - r_size;
                    r_na   <= r_pbase;
                    r_ptr  <= '0;
                end
                sgalloc_pkg::OP_ALLOC_SPLIT: begin
                    r_free  <= r_free - r_size;
                    r_na    <= r_pbase;
                    r_ptr   <= '0;
                    r_count <= r_count + CW'(1);
                end
                sgalloc_pkg::OP_FREE_MARK: begin
                    r_free <= r_free + r_flen;
                end
                sgalloc_pkg::OP_MERGE_NEXT: begin
                    r_count <= r_count - CW'(1);
                    r_ptr   <= r_f - CW'(1);
                end
                sgalloc_pkg::OP_PTR_PREV: begin
                    r_ptr <= r_f - CW'(1);
                end
                sgalloc_pkg::OP_MERGE_PREV: begin
                    r_count <= r_count - CW'(1);
                end
                sgalloc_pkg::OP_SHRINK_MERGE: begin
                    r_free <= r_free + d_shr;
                end
                sgalloc_pkg::OP_SHRINK_SPLIT: begin
                    r_free  <= r_free + d_shr;
                    r_count <= r_count + CW'(1);
                end
                sgalloc_pkg::OP_EXTEND: begin
                    r_free <= r_free - d_gr;
                end
                sgalloc_pkg::OP_EXTEND_EXACT: begin
                    r_free  <= r_free - d_gr;
                    r_count <= r_count - CW'(1);
                end
                sgalloc_pkg::OP_HOLE_START: begin
                    r_ptr   <= '0;
                    r_holes <= '0;
                    r_st    <= i_dp_cmd.st;
                    case (i_dp_cmd.rsel)
                        sgalloc_pkg::RSEL_ADDR: r_ra <= r_addr;
                        sgalloc_pkg::RSEL_NA:   r_ra <= r_na;
                        default:                r_ra <= '0;
                    endcase
                end
                sgalloc_pkg::OP_HOLE_STEP: begin
                    if (!rd_used) r_holes <= r_holes + CW'(1);
                    r_ptr <= r_ptr + CW'(1);
                end
                sgalloc_pkg::OP_OUT_LOAD: begin
                    r_o_st    <= r_st;
                    r_o_ra    <= r_ra;
                    r_o_free  <= r_free;
                    r_o_holes <= (r_free == '0) ? '0 : r_holes;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status      = r_o_st;
    assign o_result_addr = r_o_ra;
    assign o_free_total  = r_o_free;
    assign o_hole_total  = r_o_holes;

endmodule

[rtl/sgalloc_ctrl.sv]
module sgalloc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  sgalloc_pkg::t_dp_stat i_dp_stat,
    output sgalloc_pkg::t_dp_cmd  o_dp_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_ACHK = 4'd2;
    localparam logic [3:0] S_AFIT = 4'd3;
    localparam logic [3:0] S_AEND = 4'd4;
    localparam logic [3:0] S_FIND = 4'd5;
    localparam logic [3:0] S_FMARK = 4'd6;
    localparam logic [3:0] S_FNXT = 4'd7;
    localparam logic [3:0] S_FPRV = 4'd8;
    localparam logic [3:0] S_RA   = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_HOLE = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]          r_state;
    logic [3:0]          n_state;
    logic                r_move;
    logic                n_move;
    sgalloc_pkg::t_st    r_st;
    sgalloc_pkg::t_st    n_st;
    sgalloc_pkg::t_rsel  r_rsel;
    sgalloc_pkg::t_rsel  n_rsel;
    logic                r_ov;
    logic                next_ok;
    logic                free_path;

    assign next_ok   = !i_dp_stat.ptr_end && !i_dp_stat.rd_used;
    assign free_path = (i_dp_stat.cmdc == sgalloc_pkg::CMD_FREE) || r_move;

    always_comb begin
        n_state       = r_state;
        n_move        = r_move;
        n_st          = r_st;
        n_rsel        = r_rsel;
        o_dp_cmd.op   = sgalloc_pkg::OP_NOP;
        o_dp_cmd.st   = r_st;
        o_dp_cmd.rsel = r_rsel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_dp_cmd.op = sgalloc_pkg::OP_LOAD;
                    n_move      = 1'b0;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_dp_stat.cmdc)
                    sgalloc_pkg::CMD_ALLOC, sgalloc_pkg::CMD_REALLOC: begin
                        if (i_dp_stat.size_zero) begin
                            n_st    = sgalloc_pkg::ST_BADSIZE;
                            n_rsel  = sgalloc_pkg::RSEL_ZERO;
                            n_state = S_FIN;
                        end else if (i_dp_stat.cmdc == sgalloc_pkg::CMD_ALLOC) begin
                            n_state = S_ACHK;
                        end else begin
                            n_state = S_FIND;
                        end
                    end
                    sgalloc_pkg::CMD_FREE: n_state = S_FIND;
                    default: begin
                        n_st    = sgalloc_pkg::ST_NOTALLOC;
                        n_rsel  = sgalloc_pkg::RSEL_ZERO;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_ACHK: begin
                if (i_dp_stat.size_gt_free) begin
                    n_st    = sgalloc_pkg::ST_NOFIT;
                    n_rsel  = sgalloc_pkg::RSEL_ZERO;
                    n_state = S_FIN;
                end else begin
                    o_dp_cmd.op = sgalloc_pkg::OP_PTR0;
                    n_state     = S_AFIT;
                end
            end
            S_AFIT: begin
                if (i_dp_stat.ptr_end) begin
                    n_state = S_AEND;
                end else begin
                    o_dp_cmd.op = sgalloc_pkg::OP_FIT_STEP;
                    if (i_dp_stat.cand && i_dp_stat.first_pol) n_state = S_AEND;
                end
            end
            S_AEND: begin
                if (!i_dp_stat.pick_valid) begin
                    n_st    = sgalloc_pkg::ST_NOFIT;
                    n_rsel  = sgalloc_pkg::RSEL_ZERO;
                    n_state = S_FIN;
                end else if (!i_dp_stat.pick_exact && i_dp_stat.full) begin
                    n_st    = sgalloc_pkg::ST_FULL;
                    n_rsel  = sgalloc_pkg::RSEL_ZERO;
                    n_state = S_FIN;
                end else begin
                    o_dp_cmd.op = i_dp_stat.pick_exact ? sgalloc_pkg::OP_ALLOC_EXACT
                                                       : sgalloc_pkg::OP_ALLOC_SPLIT;
                    if (r_move) begin
                        // move: now release the old block
                        n_state = S_FIND;
                    end else begin
                        n_st    = sgalloc_pkg::ST_OK;
                        n_rsel  = sgalloc_pkg::RSEL_NA;
                        n_state = S_FIN;
                    end
                end
            end
            S_FIND: begin
                if (i_dp_stat.ptr_end) begin
                    n_st    = sgalloc_pkg::ST_NOTALLOC;
                    n_rsel  = sgalloc_pkg::RSEL_ZERO;
                    n_state = S_FIN;
                end else if (i_dp_stat.base_eq) begin
                    if (i_dp_stat.rd_used) begin
                        o_dp_cmd.op = sgalloc_pkg::OP_FOUND;
                        n_state     = free_path ? S_FMARK : S_RA;
                    end else begin
                        n_st    = sgalloc_pkg::ST_NOTALLOC;
                        n_rsel  = sgalloc_pkg::RSEL_ZERO;
                        n_state = S_FIN;
                    end
                end else begin
                    o_dp_cmd.op = sgalloc_pkg::OP_FIND_STEP;
                end
            end
            S_FMARK: begin
                o_dp_cmd.op = sgalloc_pkg::OP_FREE_MARK;
                n_state     = S_FNXT;
            end
            S_FNXT: begin
                o_dp_cmd.op = next_ok ? sgalloc_pkg::OP_MERGE_NEXT : sgalloc_pkg::OP_PTR_PREV;
                n_state     = S_FPRV;
            end
            S_FPRV: begin
                if (i_dp_stat.f_nz && !i_dp_stat.rd_used) begin
                    o_dp_cmd.op = sgalloc_pkg::OP_MERGE_PREV;
                end
                n_st    = sgalloc_pkg::ST_OK;
                n_rsel  = r_move ? sgalloc_pkg::RSEL_NA : sgalloc_pkg::RSEL_ADDR;
                n_state = S_FIN;
            end
            S_RA: begin
                n_st    = sgalloc_pkg::ST_OK;
                n_rsel  = sgalloc_pkg::RSEL_ADDR;
                n_state = S_FIN;
                if (i_dp_stat.shrink) begin
                    if (next_ok) begin
                        o_dp_cmd.op = sgalloc_pkg::OP_SHRINK_MERGE;
                    end else if (i_dp_stat.full) begin
                        n_st   = sgalloc_pkg::ST_FULL;
                        n_rsel = sgalloc_pkg::RSEL_ZERO;
                    end else begin
                        o_dp_cmd.op = sgalloc_pkg::OP_SHRINK_SPLIT;
                    end
                end else if (i_dp_stat.grow) begin
                    if (next_ok && i_dp_stat.next_fits) begin
                        o_dp_cmd.op = i_dp_stat.next_exact ? sgalloc_pkg::OP_EXTEND_EXACT
                                                           : sgalloc_pkg::OP_EXTEND;
                    end else begin
                        n_move  = 1'b1;
                        n_state = S_ACHK;
                    end
                end
            end
            S_FIN: begin
                o_dp_cmd.op = sgalloc_pkg::OP_HOLE_START;
                n_state     = S_HOLE;
            end
            S_HOLE: begin
                if (i_dp_stat.ptr_end) begin
                    n_state = S_DONE;
                end else begin
                    o_dp_cmd.op = sgalloc_pkg::OP_HOLE_STEP;
                end
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    o_dp_cmd.op = sgalloc_pkg::OP_OUT_LOAD;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_move  <= 1'b0;
            r_st    <= sgalloc_pkg::ST_OK;
            r_rsel  <= sgalloc_pkg::RSEL_ZERO;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_move  <= n_move;
            r_st    <= n_st;
            r_rsel  <= n_rsel;
            if (o_dp_cmd.op == sgalloc_pkg::OP_OUT_LOAD) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_ov;

endmodule

[rtl/segment_allocator_fit_policy.sv]
// segment allocator with first, best and worst fit: keeps an address-ordered
// table of up to MAX_SEGS segments tiling a pool of pool_size units and serves
// alloc, free and realloc words, one result word per command word. a command
// walks the table one entry a cycle through a single read pointer. an alloc
// runs a fit scan, then the hole count scan; first fit ends its scan at the
// first hole that fits. a free finds the block, marks it free and merges it
// with a free neighbour on either side. a realloc finds the block, shrinks it
// in place, grows it in place into a free next segment that fits, or else
// moves it: it allocates the new block, then frees the old one. a word
// rejected at dispatch goes straight to the hole count scan. inserts and
// removals shift every entry of the table at once. one word is handled at a
// time; the result sits in an output register, so the next command word is
// taken while the previous result still waits, and only the hand-off of the
// following result stalls until that one is taken. writing pool_size resets
// the table to one free segment and must only happen while the block is idle.
module segment_allocator_fit_policy #(
    parameter int MAX_SEGS  = 32,
    parameter int ADDR_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [sgalloc_pkg::SZ_W-1:0] i_cfg_wdata,
    // command words
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_cmd,
    input  logic [ADDR_BITS-1:0]         i_req_addr,
    input  logic [sgalloc_pkg::SZ_W-1:0] i_req_size,
    input  logic [1:0]                   i_fit_policy,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_status,
    output logic [sgalloc_pkg::SZ_W-1:0] o_result_addr,
    output logic [sgalloc_pkg::SZ_W-1:0] o_free_total,
    output logic [$clog2(MAX_SEGS+1)-1:0] o_hole_total
);

    sgalloc_pkg::t_dp_cmd  dp_cmd;
    sgalloc_pkg::t_dp_stat dp_stat;

    // sequencer: scans, splits, merges, hole count, output hand-off
    sgalloc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_dp_stat   (dp_stat),
        .o_dp_cmd    (dp_cmd)
    );

    // segment table, counters and the result register
    sgalloc_dp #(
        .MAX_SEGS  (MAX_SEGS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_cmd),
        .i_req_addr    (i_req_addr),
        .i_req_size    (i_req_size),
        .i_fit_policy  (i_fit_policy),
        .i_dp_cmd      (dp_cmd),
        .o_dp_stat     (dp_stat),
        .o_status      (o_status),
        .o_result_addr (o_result_addr),
        .o_free_total  (o_free_total),
        .o_hole_total  (o_hole_total)
    );

endmodule

[rtl/segment_allocator_fit_policy_chk.sv]
`include "segment_allocator_fit_policy_assert.svh"

module segment_allocator_fit_policy_chk #(
    parameter int MAX_SEGS  = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [2:0]                   o_status,
    input logic [sgalloc_pkg::SZ_W-1:0] o_result_addr,
    input logic [sgalloc_pkg::SZ_W-1:0] o_free_total,
    input logic [$clog2(MAX_SEGS+1)-1:0] o_hole_total
);

    // a stalled result word stays offered
    `SGA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid,
        "result word dropped")

    // failed commands report address zero
    `SGA_ASSERT_IMPL(a_fail_addr, o_out_valid && (o_status != sgalloc_pkg::ST_OK),
        o_result_addr == '0, "nonzero address on failure")

    // no free units means no holes
    `SGA_ASSERT_IMPL(a_no_holes, o_out_valid && (o_free_total == '0),
        o_hole_total == '0, "holes reported with empty free total")

endmodule

bind segment_allocator_fit_policy segment_allocator_fit_policy_chk #(
    .MAX_SEGS  (MAX_SEGS)
) u_chk (.*);
